// ===== hw/rtl/period_jitter_histogram_core_defines.svh =====
// Assertion macros used by the checker file of the jitter histogram.
// They expect signals named clk and rst_n in the scope of use.
`ifndef PERIOD_JITTER_HISTOGRAM_CORE_DEFINES_SVH
`define PERIOD_JITTER_HISTOGRAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PJH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pjh assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PJH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pjh assertion failed");

`endif

// ===== hw/rtl/pjh_pkg.sv =====
// ----------------------------------------------------------------------------
// pjh_pkg
// Shared constants and types of the period jitter histogram.
// ----------------------------------------------------------------------------
package pjh_pkg;

  localparam int HIST_BINS = 64;
  localparam int BIN_W     = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  localparam int TS_W      = 32;
  localparam int CNT_W     = 32;
  localparam int JIT_W     = 30;
  localparam int IDX_W     = 6;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } pjh_op_t;

  typedef struct packed {
    pjh_op_t            op;
    logic [JIT_W-1:0]   jitter;
    logic [BIN_W-1:0]   bin;
  } pjh_stage_t;

  typedef struct packed {
    logic               en;
    logic [BIN_W-1:0]   addr;
    logic [CNT_W-1:0]   data;
  } pjh_wr_t;

endpackage

// ===== hw/rtl/pjh_jitter_pipe.sv =====
// ----------------------------------------------------------------------------
// pjh_jitter_pipe
// Front stages: period measurement, deviation, rounding and bin selection.
// ----------------------------------------------------------------------------
module pjh_jitter_pipe
  import pjh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld_a,
  input  logic              ld_b,
  input  logic              ld_c,
  input  logic              in_opcode,
  input  logic [TS_W-1:0]   in_timestamp,
  input  logic [IDX_W-1:0]  in_bin_index,
  input  logic [TS_W-1:0]   expected_period,
  output pjh_stage_t        stage_c
);

  logic [TS_W-1:0]  prev_r, prev_nxt;
  pjh_op_t          op_a_r, op_b_r;
  logic [TS_W-1:0]  delta_a_r, dev_b_r, dev_nxt;
  logic [IDX_W-1:0] idx_a_r, idx_b_r;
  logic [TS_W:0]    rounded;
  logic [JIT_W-1:0] jit;
  pjh_stage_t       stage_c_r, stage_c_nxt;

  always_comb begin
    prev_nxt = prev_r;
    if (ld_a && pjh_op_t'(in_opcode) == OP_SAMPLE) begin
      prev_nxt = in_timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

  always_comb begin
    if (delta_a_r > expected_period) begin
      dev_nxt = delta_a_r - expected_period;
    end else begin
      dev_nxt = expected_period - delta_a_r;
    end
  end

  always_comb begin
    rounded = {1'b0, dev_b_r} + (TS_W+1)'(4);
    jit     = rounded[TS_W:3];
    stage_c_nxt.op = op_b_r;
    if (op_b_r == OP_SAMPLE) begin
      stage_c_nxt.jitter = jit;
      if (jit >= JIT_W'(HIST_BINS - 1)) begin
        stage_c_nxt.bin = BIN_W'(HIST_BINS - 1);
      end else begin
        stage_c_nxt.bin = jit[BIN_W-1:0];
      end
    end else begin
      stage_c_nxt.jitter = '0;
      if (JIT_W'(idx_b_r) >= JIT_W'(HIST_BINS - 1)) begin
        stage_c_nxt.bin = BIN_W'(HIST_BINS - 1);
      end else begin
        stage_c_nxt.bin = BIN_W'(idx_b_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      op_a_r    <= pjh_op_t'(in_opcode);
      delta_a_r <= in_timestamp - prev_r;
      idx_a_r   <= in_bin_index;
    end
    if (ld_b) begin
      op_b_r  <= op_a_r;
      dev_b_r <= dev_nxt;
      idx_b_r <= idx_a_r;
    end
    if (ld_c) begin
      stage_c_r <= stage_c_nxt;
    end
  end

  assign stage_c = stage_c_r;

endmodule

// ===== hw/rtl/pjh_count_ram.sv =====
// ----------------------------------------------------------------------------
// pjh_count_ram
// Histogram counter memory with registered read and per-bin valid bits.
// ----------------------------------------------------------------------------
module pjh_count_ram
  import pjh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [BIN_W-1:0]  rd_addr,
  input  pjh_wr_t           wr,
  output logic [CNT_W-1:0]  rd_count
);

  logic [CNT_W-1:0]     mem [HIST_BINS];
  logic [HIST_BINS-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]     rd_data_r;
  logic                 rd_vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // A bin never written since reset reads as zero.
  assign rd_count = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/period_jitter_histogram_core.sv =====
// ----------------------------------------------------------------------------
// period_jitter_histogram_core
// Period jitter measurement with a histogram of rounded jitter values.
// ----------------------------------------------------------------------------
// A sample item records a timestamp, measures the interval from the previous
// sample against cfg_data's expected period, and counts the rounded jitter in
// a bin of the histogram; a read item returns one bin's count. The block takes
// one item per cycle while out_stall is low and registers its result. That
// rate is set by the histogram memory, which does one read and one write each
// cycle, with the count just written forwarded to a following item on the
// same bin. The histogram reads as zero after reset through per-bin valid bits,
// so there is no clearing pass and items are accepted right after reset.
// ----------------------------------------------------------------------------
module period_jitter_histogram_core
  import pjh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TS_W-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [TS_W-1:0]   in_timestamp,
  input  logic [IDX_W-1:0]  in_bin_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [JIT_W-1:0]  out_jitter,
  output logic [IDX_W-1:0]  out_bin,
  output logic [CNT_W-1:0]  out_bin_count,
  output logic [JIT_W-1:0]  out_largest_jitter
);

  logic [TS_W-1:0]  period_r, period_nxt;
  logic             va_r, vb_r, vc_r, vd_r, vo_r;
  logic             va_nxt, vb_nxt, vc_nxt, vd_nxt, vo_nxt;
  logic             rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
  logic             ld_a, ld_b, ld_c, ld_d, ld_o;
  pjh_stage_t       stage_c, stage_d_r;
  logic [JIT_W-1:0] largest_r, largest_nxt, largest_d_r;
  logic             fwd_hit_r, fwd_hit_nxt;
  logic [CNT_W-1:0] fwd_data_r, rd_count, count_cur, count_new;
  pjh_wr_t          wr;

  assign cfg_ready  = 1'b1;
  assign period_nxt = cfg_valid ? cfg_data : period_r;

  assign rdy_o = !vo_r || !out_stall;
  assign rdy_d = !vd_r || rdy_o;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;

  assign in_stall = !rdy_a;
  assign ld_a     = in_valid && rdy_a;
  assign ld_b     = va_r && rdy_b;
  assign ld_c     = vb_r && rdy_c;
  assign ld_d     = vc_r && rdy_d;
  assign ld_o     = vd_r && rdy_o;

  assign va_nxt = ld_a || (va_r && !ld_b);
  assign vb_nxt = ld_b || (vb_r && !ld_c);
  assign vc_nxt = ld_c || (vc_r && !ld_d);
  assign vd_nxt = ld_d || (vd_r && !ld_o);
  assign vo_nxt = ld_o || (vo_r && out_stall);

  always_comb begin
    largest_nxt = largest_r;
    if (ld_d && stage_c.op == OP_SAMPLE && stage_c.jitter > largest_r) begin
      largest_nxt = stage_c.jitter;
    end
  end

  assign count_cur = fwd_hit_r ? fwd_data_r : rd_count;
  assign count_new = (stage_d_r.op == OP_SAMPLE) ? count_cur + CNT_W'(1) : count_cur;

  assign wr.en   = ld_o && stage_d_r.op == OP_SAMPLE;
  assign wr.addr = stage_d_r.bin;
  assign wr.data = count_new;

  // The item entering the count stage reads the memory in the same cycle as
  // the write of the item leaving it, so a match on the bin takes the new count.
  assign fwd_hit_nxt = wr.en && stage_d_r.bin == stage_c.bin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= '0;
      largest_r <= '0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      vc_r      <= 1'b0;
      vd_r      <= 1'b0;
      vo_r      <= 1'b0;
    end else begin
      period_r  <= period_nxt;
      largest_r <= largest_nxt;
      va_r      <= va_nxt;
      vb_r      <= vb_nxt;
      vc_r      <= vc_nxt;
      vd_r      <= vd_nxt;
      vo_r      <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_d) begin
      stage_d_r   <= stage_c;
      largest_d_r <= largest_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
      fwd_data_r  <= count_new;
    end
    if (ld_o) begin
      out_jitter         <= stage_d_r.jitter;
      out_bin            <= IDX_W'(stage_d_r.bin);
      out_bin_count      <= count_new;
      out_largest_jitter <= largest_d_r;
    end
  end

  assign out_valid = vo_r;

  pjh_jitter_pipe u_jitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .ld_a            (ld_a),
    .ld_b            (ld_b),
    .ld_c            (ld_c),
    .in_opcode       (in_opcode),
    .in_timestamp    (in_timestamp),
    .in_bin_index    (in_bin_index),
    .expected_period (period_r),
    .stage_c         (stage_c)
  );

  pjh_count_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (ld_d),
    .rd_addr  (stage_c.bin),
    .wr       (wr),
    .rd_count (rd_count)
  );

endmodule

// ===== hw/rtl/pjh_checker.sv =====
// ----------------------------------------------------------------------------
// pjh_checker
// Port-level checks of the period jitter histogram, bound to the top level.
// ----------------------------------------------------------------------------
`include "period_jitter_histogram_core_defines.svh"

module pjh_checker
  import pjh_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [JIT_W-1:0]  out_jitter,
  input logic [IDX_W-1:0]  out_bin,
  input logic [CNT_W-1:0]  out_bin_count,
  input logic [JIT_W-1:0]  out_largest_jitter
);

  `PJH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bin_count) && $stable(out_bin))
  `PJH_ASSERT_NOW(a_largest_covers, out_valid, out_jitter <= out_largest_jitter)
  `PJH_ASSERT_NOW(a_last_bin, out_valid && out_jitter >= JIT_W'(HIST_BINS - 1), out_bin == IDX_W'(HIST_BINS - 1))

endmodule

bind period_jitter_histogram_core pjh_checker u_pjh_checker (.*);

// ===== tb/period_jitter_histogram_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// period_jitter_histogram_checker
// Watches the channels of the jitter histogram core and checks its results.
// ----------------------------------------------------------------------------
// The checker follows every accepted period write and every accepted item. It
// keeps its own copy of the previous timestamp, the largest jitter and the bin
// counters. From these it works out the result each item should give and
// queues it. Each accepted result is compared field by field with the oldest
// queued result. The number of mismatches and the number of results still
// owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module period_jitter_histogram_checker
  import pjh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [TS_W-1:0]   cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_opcode,
  input  logic [TS_W-1:0]   in_timestamp,
  input  logic [IDX_W-1:0]  in_bin_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [JIT_W-1:0]  out_jitter,
  input  logic [IDX_W-1:0]  out_bin,
  input  logic [CNT_W-1:0]  out_bin_count,
  input  logic [JIT_W-1:0]  out_largest_jitter,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    logic [JIT_W-1:0] jitter;
    logic [IDX_W-1:0] bin;
    logic [CNT_W-1:0] bin_count;
    logic [JIT_W-1:0] largest_jitter;
  } jitter_result_t;

  logic [TS_W-1:0]  period_q;
  logic [TS_W-1:0]  last_stamp;
  logic [JIT_W-1:0] peak_jitter;
  logic [CNT_W-1:0] bin_counts [HIST_BINS];
  jitter_result_t   owed_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [JIT_W-1:0] value);
    if (value >= HIST_BINS) begin
      return BIN_W'(HIST_BINS - 1);
    end
    return BIN_W'(value);
  endfunction

  task automatic measure_item(input pjh_op_t op, input logic [TS_W-1:0] stamp,
                              input logic [IDX_W-1:0] index, output jitter_result_t res);
    logic [TS_W-1:0]  delta;
    logic [TS_W:0]    deviation;
    logic [TS_W:0]    rounded;
    logic [BIN_W-1:0] b;
    res.jitter = '0;
    if (op == OP_SAMPLE) begin
      delta     = stamp - last_stamp;
      deviation = (delta > period_q) ? {1'b0, delta - period_q} : {1'b0, period_q - delta};
      rounded   = (deviation + 33'd4) >> 3;
      res.jitter = rounded[JIT_W-1:0];
      if (res.jitter > peak_jitter) begin
        peak_jitter = res.jitter;
      end
      b = clamp_bin(res.jitter);
      bin_counts[b] = bin_counts[b] + 1'b1;
      last_stamp = stamp;
    end else begin
      b = clamp_bin(JIT_W'(index));
    end
    res.bin            = IDX_W'(b);
    res.bin_count      = bin_counts[b];
    res.largest_jitter = peak_jitter;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    jitter_result_t want;
    jitter_result_t fresh;
    if (!rst_n) begin
      period_q    = '0;
      last_stamp  = '0;
      peak_jitter = '0;
      for (int i = 0; i < HIST_BINS; i++) begin
        bin_counts[i] = '0;
      end
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_q = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: result with no item pending, jitter %0d bin %0d count %0d",
                   $time, out_jitter, out_bin, out_bin_count);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("jitter", 32'(want.jitter), 32'(out_jitter));
          check_field("bin", 32'(want.bin), 32'(out_bin));
          check_field("bin_count", 32'(want.bin_count), 32'(out_bin_count));
          check_field("largest_jitter", 32'(want.largest_jitter), 32'(out_largest_jitter));
        end
      end
      if (in_valid && !in_stall) begin
        measure_item(pjh_op_t'(in_opcode), in_timestamp, in_bin_index, fresh);
        owed_results.push_back(fresh);
      end
    end
    outstanding <= owed_results.size();
  end

endmodule

// ===== tb/tb_period_jitter_histogram_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_period_jitter_histogram_core
// Testbench of the period jitter histogram core.
// ----------------------------------------------------------------------------
// A directed part covers the first sample after reset, timestamp wrap, the
// smallest and largest periods, rounding at the edges, the overflow bin and
// reads of the extreme bins. Random phases then run with several periods,
// mostly on-period samples with random jitter, mixed with reads and random
// timestamps. Both sides idle in random bursts, the receiver holds off once
// for a long stretch, and the last phase runs without idling. A checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_period_jitter_histogram_core;
  import pjh_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int HOLD_CYCLES     = 160;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 240;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [TS_W-1:0]   cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              in_opcode    = OP_SAMPLE;
  logic [TS_W-1:0]   in_timestamp = '0;
  logic [IDX_W-1:0]  in_bin_index = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [JIT_W-1:0]  out_jitter;
  logic [IDX_W-1:0]  out_bin;
  logic [CNT_W-1:0]  out_bin_count;
  logic [JIT_W-1:0]  out_largest_jitter;

  int                fail_count;
  int                outstanding;
  int                cycle_count = 0;
  logic              quiet       = 1'b0;
  logic              hold_req    = 1'b0;
  logic              hold_done   = 1'b0;
  logic [TS_W-1:0]   stamp_now   = '0;
  logic [TS_W-1:0]   cur_period  = '0;

  always #4 clk = ~clk;

  period_jitter_histogram_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_timestamp       (in_timestamp),
    .in_bin_index       (in_bin_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_jitter         (out_jitter),
    .out_bin            (out_bin),
    .out_bin_count      (out_bin_count),
    .out_largest_jitter (out_largest_jitter)
  );

  period_jitter_histogram_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_timestamp       (in_timestamp),
    .in_bin_index       (in_bin_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_jitter         (out_jitter),
    .out_bin            (out_bin),
    .out_bin_count      (out_bin_count),
    .out_largest_jitter (out_largest_jitter),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input pjh_op_t op, input logic [TS_W-1:0] stamp,
                           input logic [IDX_W-1:0] index);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_timestamp <= stamp;
    in_bin_index <= index;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_sample(input logic [TS_W-1:0] stamp);
    stamp_now = stamp;
    send_item(OP_SAMPLE, stamp, IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] index);
    send_item(OP_READ, $urandom, index);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [TS_W-1:0] period);
    cur_period = period;
    cfg_valid <= 1'b1;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TS_W-1:0] phase_periods [NUM_PHASES];
    logic [TS_W-1:0] offset;
    int              pick;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_read(IDX_W'(0));
    send_sample(32'd100);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd5);
    send_read(IDX_W'(13));
    send_read(IDX_W'(63));
    wait_idle();

    write_period(32'd1000);
    send_sample(stamp_now + 32'd1000);
    send_sample(stamp_now + 32'd1003);
    send_sample(stamp_now + 32'd996);
    send_sample(stamp_now + 32'd1004);
    send_sample(stamp_now + 32'd997);
    send_sample(stamp_now + 32'd1012);
    send_sample(stamp_now + 32'd1500);
    send_sample(stamp_now + 32'd1508);
    send_sample(stamp_now + 32'd500);
    send_read(IDX_W'(1));
    send_read(IDX_W'(62));
    wait_idle();

    write_period(32'hFFFF_FFFF);
    send_sample(stamp_now);
    send_sample(stamp_now + 32'hFFFF_FFFF);
    send_read(IDX_W'(63));
    send_read(IDX_W'(0));

    phase_periods[0] = 32'd0;
    phase_periods[1] = 32'd1000;
    phase_periods[2] = 32'hFFFF_FFFF;
    phase_periods[3] = $urandom;
    phase_periods[4] = 32'd8;
    phase_periods[5] = $urandom | 32'h8000_0000;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == NUM_PHASES - 1) begin
        quiet <= 1'b1;
      end
      write_period(phase_periods[p]);
      if (p == 1) begin
        hold_req <= 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          offset = $urandom_range(0, 560);
          if ($urandom_range(0, 1) == 1) begin
            send_sample(stamp_now + cur_period - offset);
          end else begin
            send_sample(stamp_now + cur_period + offset);
          end
        end else if (pick < 80) begin
          send_read(IDX_W'($urandom));
        end else if (pick < 90) begin
          send_sample($urandom);
        end else begin
          send_sample(stamp_now + cur_period + $urandom_range(0, 16) - 32'd8);
        end
      end
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
